// File: rtl/uolf_pkg.sv
// Shared codes and controller/datapath interface types for the unique-only list filter.
package uolf_pkg;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_LIST   = 2'd1;
  localparam logic [1:0] CMD_REDUCE = 2'd2;

  localparam logic [1:0] ST_APPENDED = 2'd0;
  localparam logic [1:0] ST_DROPPED  = 2'd1;
  localparam logic [1:0] ST_ELEMENT  = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic       app_wr;
    logic       out_load;
    logic [1:0] out_status;
    logic       idx_clr;
    logic       idx_inc;
    logic       rd_list;
    logic       i_clr;
    logic       i_inc;
    logic       rd_i;
    logic       vi_load;
    logic       j_clr;
    logic       j_inc;
    logic       rd_j;
    logic       cmp;
    logic       kept_clr;
    logic       keep_wr;
    logic       commit;
  } uolf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic idx_last;
    logic i_last;
    logic j_last;
    logic slot_free;
  } uolf_sts_t;

endpackage

// File: rtl/unique_only_list_filter.sv
// Top level of the unique-only list filter: controller, datapath and checks.
// An ordered store of up to DEPTH signed 32-bit values, with one command per
// transfer on the input channel. An append gives one result (appended, or
// dropped when full), so appends stream at one per cycle while the output
// register drains. A list walks the store through the single read port of
// the live bank, reading each element and then emitting it, and waits out
// any output stall. A reduce first scans the store pairwise with that same
// read port: for each entry it fetches it, latches it, reads and compares
// every entry against it, and then keeps or drops it; the list walk follows.
// Survivors are written in order to the second bank, which then becomes the
// live one, so no copy-back is needed. Listing an empty store, or a reduce
// that leaves nothing, gives one result with status empty. Command code 3 is
// taken and ignored. The store needs no clearing after reset; only entries
// below the count are ever read.
module unique_only_list_filter import uolf_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic signed [31:0] item,
  output logic               last
);

  uolf_cmd_t ctl;
  uolf_sts_t sts;

  uolf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts),
    .ctl      (ctl)
  );

  uolf_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .value     (value),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .status    (status),
    .item      (item),
    .last      (last)
  );

  // An append taken on a full store must report the drop next cycle.
  a_drop_when_full: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (cmd == CMD_APPEND) && sts.full)
      |=> (out_valid && (status == ST_DROPPED)))
    else $error("append on full store not reported as dropped");

  // Non-element results are single transfers.
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_ELEMENT)) |-> last)
    else $error("non-element result without last");

  // Only list elements carry a value.
  a_item_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_ELEMENT)) |-> (item == 32'sd0))
    else $error("non-element result with non-zero item");

  // A command is only taken when the output register can take its result.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> (!out_valid || !out_stall))
    else $error("command taken while output register blocked");

endmodule

// File: rtl/uolf_dp.sv
// Datapath: two store banks, entry count, walk indexes, compare logic and output register.
module uolf_dp import uolf_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  uolf_cmd_t          ctl,
  output uolf_sts_t          sts,
  input  logic signed [31:0] value,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [1:0]         status,
  output logic signed [31:0] item,
  output logic               last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [31:0]   mem0 [DEPTH];
  logic [31:0]   mem1 [DEPTH];

  logic [CW-1:0] count;
  logic          bsel;
  logic [AW-1:0] idx;
  logic [AW-1:0] i;
  logic [AW-1:0] j;
  logic [CW-1:0] kept;
  logic [31:0]   vi;
  logic          dup;
  logic [31:0]   rdata;

  logic [AW-1:0] rd_addr;
  logic          rd_en;
  logic          keep_en;
  logic          wr_en0;
  logic          wr_en1;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic [CW-1:0] count_m1;

  assign count_m1 = count - CW'(1);

  assign sts.full      = (count == CW'(DEPTH));
  assign sts.empty     = (count == '0);
  assign sts.idx_last  = (CW'(idx) == count_m1);
  assign sts.i_last    = (CW'(i) == count_m1);
  assign sts.j_last    = (CW'(j) == count_m1);
  assign sts.slot_free = !out_valid || !out_stall;

  // one read port on the live bank
  assign rd_en   = ctl.rd_list | ctl.rd_i | ctl.rd_j;
  assign rd_addr = ctl.rd_list ? idx : (ctl.rd_i ? i : j);

  // appends go to the live bank, survivors of a reduce to the other one
  assign keep_en = ctl.keep_wr && !dup;
  assign wr_en0  = (ctl.app_wr && !bsel) || (keep_en && bsel);
  assign wr_en1  = (ctl.app_wr && bsel) || (keep_en && !bsel);
  assign wr_addr = ctl.app_wr ? count[AW-1:0] : kept[AW-1:0];
  assign wr_data = ctl.app_wr ? value : vi;

  always_ff @(posedge clk) begin
    if (wr_en0) begin
      mem0[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en1) begin
      mem1[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= bsel ? mem1[rd_addr] : mem0[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      bsel      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.commit) begin
        count <= kept;
        bsel  <= ~bsel;
      end else if (ctl.app_wr) begin
        count <= count + CW'(1);
      end
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.idx_clr) begin
      idx <= '0;
    end else if (ctl.idx_inc) begin
      idx <= idx + AW'(1);
    end
    if (ctl.i_clr) begin
      i <= '0;
    end else if (ctl.i_inc) begin
      i <= i + AW'(1);
    end
    if (ctl.j_clr) begin
      j <= '0;
    end else if (ctl.j_inc) begin
      j <= j + AW'(1);
    end
    if (ctl.kept_clr) begin
      kept <= '0;
    end else if (keep_en) begin
      kept <= kept + CW'(1);
    end
    if (ctl.vi_load) begin
      vi <= rdata;
    end
    if (ctl.vi_load) begin
      dup <= 1'b0;
    end else if (ctl.cmp && (j != i) && (rdata == vi)) begin
      dup <= 1'b1;
    end
    if (ctl.out_load) begin
      status <= ctl.out_status;
      item   <= (ctl.out_status == ST_ELEMENT) ? rdata : 32'sd0;
      last   <= (ctl.out_status == ST_ELEMENT) ? sts.idx_last : 1'b1;
    end
  end

endmodule

// File: rtl/uolf_ctrl.sv
// Controller: command decode and sequencing of append, list and reduce walks.
module uolf_ctrl import uolf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] cmd,
  input  uolf_sts_t  sts,
  output uolf_cmd_t  ctl
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LIST_RD,
    S_LIST_EMIT,
    S_RED_RDI,
    S_RED_LDI,
    S_RED_RDJ,
    S_RED_CMP,
    S_RED_KEEP,
    S_RED_DONE,
    S_LIST_START,
    S_EMPTY_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_stall = !((state == S_IDLE) && sts.slot_free);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_APPEND: begin
              ctl.out_load   = 1'b1;
              ctl.out_status = sts.full ? ST_DROPPED : ST_APPENDED;
              ctl.app_wr     = !sts.full;
            end
            CMD_LIST: begin
              if (sts.empty) begin
                ctl.out_load   = 1'b1;
                ctl.out_status = ST_EMPTY;
              end else begin
                ctl.idx_clr = 1'b1;
                state_next  = S_LIST_RD;
              end
            end
            CMD_REDUCE: begin
              if (sts.empty) begin
                ctl.out_load   = 1'b1;
                ctl.out_status = ST_EMPTY;
              end else begin
                ctl.i_clr    = 1'b1;
                ctl.kept_clr = 1'b1;
                state_next   = S_RED_RDI;
              end
            end
            default: ;
          endcase
        end
      end
      S_LIST_RD: begin
        ctl.rd_list = 1'b1;
        state_next  = S_LIST_EMIT;
      end
      S_LIST_EMIT: begin
        if (sts.slot_free) begin
          ctl.out_load   = 1'b1;
          ctl.out_status = ST_ELEMENT;
          if (sts.idx_last) begin
            state_next = S_IDLE;
          end else begin
            ctl.idx_inc = 1'b1;
            state_next  = S_LIST_RD;
          end
        end
      end
      S_RED_RDI: begin
        ctl.rd_i   = 1'b1;
        state_next = S_RED_LDI;
      end
      S_RED_LDI: begin
        ctl.vi_load = 1'b1;
        ctl.j_clr   = 1'b1;
        state_next  = S_RED_RDJ;
      end
      S_RED_RDJ: begin
        ctl.rd_j   = 1'b1;
        state_next = S_RED_CMP;
      end
      S_RED_CMP: begin
        ctl.cmp = 1'b1;
        if (sts.j_last) begin
          state_next = S_RED_KEEP;
        end else begin
          ctl.j_inc  = 1'b1;
          state_next = S_RED_RDJ;
        end
      end
      S_RED_KEEP: begin
        ctl.keep_wr = 1'b1;
        if (sts.i_last) begin
          state_next = S_RED_DONE;
        end else begin
          ctl.i_inc  = 1'b1;
          state_next = S_RED_RDI;
        end
      end
      S_RED_DONE: begin
        ctl.commit  = 1'b1;
        ctl.idx_clr = 1'b1;
        state_next  = S_LIST_START;
      end
      S_LIST_START: begin
        state_next = sts.empty ? S_EMPTY_EMIT : S_LIST_RD;
      end
      S_EMPTY_EMIT: begin
        if (sts.slot_free) begin
          ctl.out_load   = 1'b1;
          ctl.out_status = ST_EMPTY;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: test/unique_only_list_filter_check.sv
// Checker for the unique-only list filter: predicts each command's results and compares them.
`timescale 1ns / 100ps
module unique_only_list_filter_check import uolf_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic signed [31:0] value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         status,
  input  logic signed [31:0] item,
  input  logic               last,
  output int                 errors,
  output int                 pending,
  output int                 results_seen
);

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] item;
    logic               last;
  } filter_result_t;

  filter_result_t     expected_results[$];
  logic signed [31:0] shadow_store [DEPTH];
  int                 shadow_count;

  initial begin
    errors       = 0;
    pending      = 0;
    results_seen = 0;
    shadow_count = 0;
  end

  function automatic filter_result_t make_result(logic [1:0] code, logic signed [31:0] data,
                                                 logic tail);
    filter_result_t r;
    r.status = code;
    r.item   = data;
    r.last   = tail;
    return r;
  endfunction

  task automatic emit_store();
    int k;
    if (shadow_count == 0) begin
      expected_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
    end else begin
      for (k = 0; k < shadow_count; k++)
        expected_results.push_back(make_result(ST_ELEMENT, shadow_store[k],
                                               k == shadow_count - 1));
    end
  endtask

  // keep only values that occur exactly once, order preserved
  task automatic drop_repeated_values();
    logic signed [31:0] survivors [DEPTH];
    int kept;
    int hits;
    int i;
    int j;
    kept = 0;
    for (i = 0; i < shadow_count; i++) begin
      hits = 0;
      for (j = 0; j < shadow_count; j++)
        if (shadow_store[j] == shadow_store[i]) hits++;
      if (hits == 1) begin
        survivors[kept] = shadow_store[i];
        kept++;
      end
    end
    for (i = 0; i < kept; i++) shadow_store[i] = survivors[i];
    shadow_count = kept;
  endtask

  task automatic predict_command(logic [1:0] code, logic signed [31:0] data);
    case (code)
      CMD_APPEND: begin
        if (shadow_count < DEPTH) begin
          shadow_store[shadow_count] = data;
          shadow_count++;
          expected_results.push_back(make_result(ST_APPENDED, '0, 1'b1));
        end else begin
          expected_results.push_back(make_result(ST_DROPPED, '0, 1'b1));
        end
      end
      CMD_LIST: emit_store();
      CMD_REDUCE: begin
        drop_repeated_values();
        emit_store();
      end
      default: ; // unused code: no result, no state change
    endcase
  endtask

  task automatic check_result();
    filter_result_t want;
    bit             bad;
    results_seen++;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result: status %0d item %0d last %0b",
               $time, status, item, last);
      errors++;
    end else begin
      want = expected_results.pop_front();
      bad  = 1'b0;
      if (status !== want.status) begin
        $display("%0t: status expected %0d, got %0d", $time, want.status, status);
        bad = 1'b1;
      end
      if (item !== want.item) begin
        $display("%0t: item expected %0d, got %0d", $time, want.item, item);
        bad = 1'b1;
      end
      if (last !== want.last) begin
        $display("%0t: last expected %0b, got %0b", $time, want.last, last);
        bad = 1'b1;
      end
      if (bad) errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_results.delete();
      shadow_count = 0;
    end else begin
      // an output at this edge cannot stem from an input taken at the same edge
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) predict_command(cmd, value);
    end
    pending <= expected_results.size();
  end

endmodule

// File: test/unique_only_list_filter_test.sv
// Testbench top for the unique-only list filter: stimulus, receiver, watchdog and verdict.
`timescale 1ns / 100ps
module unique_only_list_filter_test;
  import uolf_pkg::*;

  localparam int DEPTH          = 64;
  localparam int WATCHDOG_LIMIT = 40000; // must outlast the quiet scan of a full-store reduce
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off to back the block up
  localparam int DRAIN_CYCLES   = 50;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic [1:0]         cmd       = CMD_APPEND;
  logic signed [31:0] value     = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [1:0]         status;
  logic signed [31:0] item;
  logic               last;

  int errors;
  int pending;
  int results_seen;

  // idling percentages for the current phase
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;

  // long hold-off request, serviced by the receiver process
  logic hold_go    = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left  = 0;

  int sent_count [4] = '{default: 0};
  int random_items   = 0;
  int quiet_cycles   = 0;

  always #5 clk = ~clk;

  unique_only_list_filter #(.DEPTH(DEPTH)) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .item      (item),
    .last      (last)
  );

  unique_only_list_filter_check #(.DEPTH(DEPTH)) u_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .item         (item),
    .last         (last),
    .errors       (errors),
    .pending      (pending),
    .results_seen (results_seen)
  );

  // Receiver: random stalls per phase, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Watchdog: any transfer on either channel counts as progress.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", quiet_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One command transfer; the sender may idle first. Valid stays high between
  // back-to-back commands so no step sees two assignments to it.
  task automatic send(logic [1:0] code, logic signed [31:0] data);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= code;
    value    <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count[code]++;
  endtask

  // Small pool so that repeats are common and reduce has work to do.
  function automatic logic signed [31:0] pool_value();
    case ($urandom_range(9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return -1;
      default: return $urandom_range(6, 1);
    endcase
  endfunction

  function automatic logic signed [31:0] any_value();
    if ($urandom_range(1)) return pool_value();
    return $urandom();
  endfunction

  // A run of appends, with the odd unused code mixed in as noise, usually
  // closed by a list or a reduce with a junk value.
  task automatic random_burst();
    int n;
    n = $urandom_range(12, 1);
    repeat (n) begin
      if ($urandom_range(9) == 0) send(CMD_UNUSED, $urandom());
      send(CMD_APPEND, any_value());
      random_items++;
    end
    case ($urandom_range(4))
      0, 1: begin
        send(CMD_LIST, $urandom());
        random_items++;
      end
      2, 3: begin
        send(CMD_REDUCE, $urandom());
        random_items++;
      end
      default: ; // keep growing the store
    endcase
  endtask

  // Overfill the store so that the dropped status shows up, then list and
  // reduce the biggest possible store.
  task automatic fill_store();
    repeat (DEPTH + 3) begin
      send(CMD_APPEND, any_value());
      random_items++;
    end
    send(CMD_LIST, $urandom());
    send(CMD_REDUCE, $urandom());
    random_items += 2;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty store, unused code, value extremes, repeats, a reduce
    // that keeps some values and one that wipes the store.
    send(CMD_LIST, '0);
    send(CMD_REDUCE, VAL_MAX);
    send(CMD_UNUSED, 32'sh1234_5678);
    send(CMD_APPEND, VAL_MIN);
    send(CMD_APPEND, VAL_MAX);
    send(CMD_APPEND, '0);
    send(CMD_APPEND, -1);
    send(CMD_APPEND, VAL_MAX);
    send(CMD_APPEND, 5);
    send(CMD_APPEND, 5);
    send(CMD_LIST, VAL_MIN);
    send(CMD_REDUCE, '0);    // leaves min, 0, -1
    send(CMD_LIST, -1);
    send(CMD_UNUSED, VAL_MIN);
    send(CMD_APPEND, -1);
    send(CMD_APPEND, '0);
    send(CMD_APPEND, VAL_MIN);
    send(CMD_REDUCE, 7);     // every value now repeats: store empties
    send(CMD_LIST, '0);
    send(CMD_APPEND, 42);
    send(CMD_LIST, -1);
    send(CMD_REDUCE, VAL_MAX);

    // Phase 1: no idling. The receiver holds off for a long stretch while
    // the store is overfilled, so the output backs up into the input.
    hold_go <= 1'b1;
    fill_store();
    while (random_items < 90) random_burst();

    // Phase 2: sender mostly idle.
    tx_idle_pct = 78;
    while (random_items < 120) random_burst();

    // Phase 3: receiver mostly stalled.
    tx_idle_pct = 0;
    rx_stall_pct <= 78;
    while (random_items < 150) random_burst();

    // Phase 4: light idling on both sides.
    tx_idle_pct = 18;
    rx_stall_pct <= 18;
    while (random_items < 185) random_burst();

    in_valid <= 1'b0;
    // one edge first so the checker's count includes the final command
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d appends, %0d lists, %0d reduces and %0d unused codes,",
             sent_count[CMD_APPEND], sent_count[CMD_LIST], sent_count[CMD_REDUCE],
             sent_count[CMD_UNUSED]);
    $display("with %0d results checked across four idling phases.", results_seen);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
